// ===== design/mrq_pkg.sv =====
// Shared types, constants and ring-index helpers for the multilevel ring queue.
// Used by the controller, the datapath and the top level; no dependencies.
package mrq_pkg;

  localparam int DEPTH  = 16;
  localparam int LEVELS = 4;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ADDR_W = $clog2(LEVELS * DEPTH);
  localparam int TOT_W  = $clog2(LEVELS * (DEPTH - 1) + 1);
  localparam int FILL_W = PTR_W + 1;

  localparam logic [1:0] ST_ADDED     = 2'd0;
  localparam logic [1:0] ST_REMOVED   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [3:0] proc_id;
    logic [1:0] proc_priority;
    logic       cpu_event;
  } in_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] level_used;
    logic [3:0] level_count;
    logic [5:0] total_count;
  } out_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_APPEND = 5'b00010,
    S_SEARCH = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic append;
    logic search;
    logic shift;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic new_remove;
    logic search_hit;
    logic search_miss;
    logic shift_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) r = '0;
    else                        r = p + PTR_W'(1);
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == '0) r = PTR_W'(DEPTH - 1);
    else         r = p - PTR_W'(1);
    return r;
  endfunction

  // Priority reduced modulo LEVELS; the value is at most 3, so three steps do.
  function automatic logic [LVL_W-1:0] level_of(input logic [1:0] prio);
    logic [2:0] v;
    v = {1'b0, prio};
    for (int k = 0; k < 3; k++) begin
      if (v >= 3'(LEVELS)) v = v - 3'(LEVELS);
    end
    return LVL_W'(v);
  endfunction

endpackage

// ===== design/mrq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrq_ram #(
  parameter int WIDTH = 4,
  parameter int WORDS = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(WORDS)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(WORDS)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/mrq_ctrl.sv =====
// Request sequencer: append, search, shift and result hand-off.
// Depends on mrq_pkg; drives commands into mrq_dp and reads its status.
module mrq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mrq_pkg::dp_stat_t stat,
  output mrq_pkg::ctrl_cmd_t cmd
);
  import mrq_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = stat.new_remove ? S_SEARCH : S_APPEND;
      end
      S_APPEND: state_nxt = S_FINISH;
      S_SEARCH: begin
        if (stat.search_hit)       state_nxt = S_SHIFT;
        else if (stat.search_miss) state_nxt = S_FINISH;
      end
      S_SHIFT: begin
        if (stat.shift_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.append = (state_r == S_APPEND);
  assign cmd.search = (state_r == S_SEARCH);
  assign cmd.shift  = (state_r == S_SHIFT);
  assign cmd.emit   = (state_r == S_FINISH) && stat.out_free;

endmodule

// ===== design/mrq_dp.sv =====
// Datapath: slot RAM, per-level head/tail indexes, total count, result register.
// Depends on mrq_pkg and mrq_ram; steered by mrq_ctrl commands.
module mrq_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  mrq_pkg::in_req_t   in_data,
  input  mrq_pkg::ctrl_cmd_t cmd,
  output mrq_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  logic               out_stall,
  output mrq_pkg::out_rsp_t  out_data
);
  import mrq_pkg::*;

  logic [PTR_W-1:0]  head_r [LEVELS];
  logic [PTR_W-1:0]  tail_r [LEVELS];
  logic [TOT_W-1:0]  total_r;

  logic [3:0]        id_r;
  logic [LVL_W-1:0]  lvl_r;
  logic [1:0]        status_r;

  logic [PTR_W-1:0]  ptr_r;
  logic [PTR_W-1:0]  cmp_ptr_r;
  logic              cmp_vld_r;
  logic [PTR_W-1:0]  wr_ptr_r;
  logic              wr_vld_r;

  logic              out_valid_r;
  out_rsp_t          out_data_r;

  logic [PTR_W-1:0]  lvl_head, lvl_tail, rd_ptr;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [3:0]        rdata, wdata;
  logic              we, full;
  logic [FILL_W-1:0] fill;
  logic [LVL_W-1:0]  new_lvl;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lv,
                                                  input logic [PTR_W-1:0] p);
    return ADDR_W'(lv) * ADDR_W'(DEPTH) + ADDR_W'(p);
  endfunction

  always_comb begin
    lvl_head = head_r[lvl_r];
    lvl_tail = tail_r[lvl_r];
    full     = (ptr_next(lvl_tail) == lvl_head);
    new_lvl  = in_data.cpu_event ? level_of(in_data.proc_priority) : '0;

    rd_ptr = cmd.shift ? ptr_prev(ptr_r) : ptr_r;
    raddr  = slot_addr(lvl_r, rd_ptr);

    we    = (cmd.append && !full) || (cmd.shift && wr_vld_r);
    waddr = cmd.append ? slot_addr(lvl_r, lvl_tail) : slot_addr(lvl_r, wr_ptr_r);
    wdata = cmd.append ? id_r : rdata;

    if (lvl_tail >= lvl_head) fill = {1'b0, lvl_tail} - {1'b0, lvl_head};
    else fill = {1'b0, lvl_tail} + FILL_W'(DEPTH) - {1'b0, lvl_head};

    stat.new_remove  = (in_data.req_type == REQ_REMOVE);
    stat.search_hit  = cmd.search && cmp_vld_r && (rdata == id_r);
    stat.search_miss = cmd.search && !cmp_vld_r && (ptr_r == lvl_tail);
    stat.shift_done  = cmd.shift && (ptr_r == lvl_head) && !wr_vld_r;
    stat.out_free    = !out_valid_r || !out_stall;
  end

  mrq_ram #(
    .WIDTH (4),
    .WORDS (LEVELS * DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Request capture and search/shift walk.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
      wr_vld_r  <= 1'b0;
    end else if (cmd.load) begin
      id_r      <= in_data.proc_id;
      lvl_r     <= new_lvl;
      ptr_r     <= head_r[new_lvl];
      cmp_vld_r <= 1'b0;
      wr_vld_r  <= 1'b0;
    end else if (cmd.search) begin
      if (stat.search_hit) begin
        // restart the walk at the matching slot, moving toward the head
        ptr_r    <= cmp_ptr_r;
        wr_vld_r <= 1'b0;
      end else if (!stat.search_miss) begin
        cmp_ptr_r <= ptr_r;
        cmp_vld_r <= (ptr_r != lvl_tail);
        if (ptr_r != lvl_tail) ptr_r <= ptr_next(ptr_r);
      end
    end else if (cmd.shift && !stat.shift_done) begin
      // read prev slot now, write it one slot up next cycle
      wr_ptr_r <= ptr_r;
      wr_vld_r <= (ptr_r != lvl_head);
      if (ptr_r != lvl_head) ptr_r <= ptr_prev(ptr_r);
    end
  end

  // Queue indexes, totals and request status.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LEVELS; k++) begin
        head_r[k] <= '0;
        tail_r[k] <= '0;
      end
      total_r <= '0;
    end else begin
      if (cmd.append) begin
        if (full) begin
          status_r <= ST_FULL;
        end else begin
          tail_r[lvl_r] <= ptr_next(lvl_tail);
          total_r       <= total_r + TOT_W'(1);
          status_r      <= ST_ADDED;
        end
      end
      if (stat.search_miss) status_r <= ST_NOT_FOUND;
      if (stat.shift_done) begin
        head_r[lvl_r] <= ptr_next(lvl_head);
        if (total_r != '0) total_r <= total_r - TOT_W'(1);
        status_r <= ST_REMOVED;
      end
    end
  end

  // Result register: hold until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.status      <= status_r;
      out_data_r.level_used  <= 2'(lvl_r);
      out_data_r.level_count <= 4'(fill);
      out_data_r.total_count <= 6'(total_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/multilevel_ring_queue_remove_by_id.sv =====
// Multilevel ring queue with append and remove-by-id, one request at a time.
// An append passes through the append and finish states. A remove walks the addressed
// level in the search state and, on a hit, the shift state, one slot per cycle through
// the slot RAM's read and write ports, and then goes to the finish state.
// Throughput: one request in flight; the next is taken only once the result is registered for output.
// Reset (rst_n low, synchronous) empties every level and clears the total count.
module multilevel_ring_queue_remove_by_id (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mrq_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mrq_pkg::out_rsp_t out_data
);
  import mrq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mrq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mrq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
